FILE: design/decimal_string_to_int32_assert.svh
// assertion macros for the decimal string parser
`ifndef DECIMAL_STRING_TO_INT32_ASSERT_SVH
`define DECIMAL_STRING_TO_INT32_ASSERT_SVH

// same-cycle implication under reset
`define DSI_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("dsi assertion failed");

// next-cycle implication under reset
`define DSI_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("dsi assertion failed");

`endif

FILE: design/dsi_pkg.sv
`default_nettype none
package dsi_pkg;

  localparam int BUFFER_BYTES_DEF = 32;
  localparam int MAG_W = 32;
  localparam int ACC_W = 36;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [ACC_W-1:0] LIMIT_POS = 36'h07FFFFFFF;
  localparam logic [ACC_W-1:0] LIMIT_NEG = 36'h080000000;

  typedef enum logic [2:0] {
    PH_BLANK,
    PH_SPACE,
    PH_SIGN,
    PH_DIGIT,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic signed [MAG_W-1:0] value;
    logic                    ok;
  } result_t;

endpackage
`default_nettype wire

FILE: design/dsi_in_if.sv
`default_nettype none
interface dsi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last;
  logic       no_chars;

  modport source (output valid, output char_byte, output last, output no_chars, input ready);
  modport sink (input valid, input char_byte, input last, input no_chars, output ready);
endinterface
`default_nettype wire

FILE: design/dsi_out_if.sv
`default_nettype none
interface dsi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               ok;

  modport source (output valid, output value, output ok, input ready);
  modport sink (input valid, input value, input ok, output ready);
endinterface
`default_nettype wire

FILE: design/dsi_digit.sv
`default_nettype none
module dsi_digit (
  input  wire logic [dsi_pkg::MAG_W-1:0] mag,
  input  wire logic                      negative,
  input  wire logic                      failed,
  input  wire logic [3:0]                digit,
  output logic      [dsi_pkg::MAG_W-1:0] mag_next,
  output logic                           failed_next
);
  import dsi_pkg::*;

  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] limit;

  // magnitude times ten plus digit, as two shifted adds
  assign acc = (ACC_W'(mag) << 3) + (ACC_W'(mag) << 1) + ACC_W'(digit);
  assign limit = negative ? LIMIT_NEG : LIMIT_POS;

  always_comb begin
    mag_next = mag;
    failed_next = failed;
    if (!failed) begin
      if (acc > limit) begin
        failed_next = 1'b1;
      end else begin
        mag_next = acc[MAG_W-1:0];
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/dsi_parse.sv
`default_nettype none
module dsi_parse #(
  parameter int BUFFER_BYTES = dsi_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      char_byte,
  input  wire logic            last,
  input  wire logic            no_chars,
  output dsi_pkg::result_t     res
);
  import dsi_pkg::*;

  localparam int CNT_W = $clog2(BUFFER_BYTES);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUFFER_BYTES - 1);

  phase_t             phase, phase_next;
  logic [CNT_W-1:0]   counted, counted_next;
  logic [MAG_W-1:0]   magnitude, magnitude_next;
  logic               negative, negative_next;
  logic               failed, failed_next;

  logic               is_digit, is_space, is_blank;
  phase_t             src_phase;
  phase_t             cb_phase;
  logic               cb_negative, cb_failed;
  logic [MAG_W-1:0]   cb_mag;
  logic [MAG_W-1:0]   dg_mag;
  logic               dg_failed;

  assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign is_space = (char_byte == CH_SPACE) || ((char_byte >= CH_TAB) && (char_byte <= CH_CR));
  assign is_blank = (char_byte == CH_SPACE) || (char_byte == CH_TAB);
  assign src_phase = (phase == PH_BLANK) ? PH_SPACE : phase;

  dsi_digit u_digit (
    .mag         (magnitude),
    .negative    (negative),
    .failed      (failed),
    .digit       (4'(char_byte - CH_ZERO)),
    .mag_next    (dg_mag),
    .failed_next (dg_failed)
  );

  // one byte of counted text
  always_comb begin
    cb_phase = src_phase;
    cb_negative = negative;
    cb_failed = failed;
    cb_mag = magnitude;
    case (src_phase)
      PH_SPACE: begin
        if (is_space) begin
          cb_phase = PH_SPACE;
        end else if (char_byte == CH_PLUS || char_byte == CH_MINUS) begin
          cb_negative = (char_byte == CH_MINUS);
          cb_phase = PH_SIGN;
        end else if (is_digit) begin
          cb_mag = dg_mag;
          cb_failed = dg_failed;
          cb_phase = PH_DIGIT;
        end else begin
          cb_failed = 1'b1;
          cb_phase = PH_DONE;
        end
      end
      PH_SIGN: begin
        if (is_digit) begin
          cb_mag = dg_mag;
          cb_failed = dg_failed;
          cb_phase = PH_DIGIT;
        end else begin
          cb_failed = 1'b1;
          cb_phase = PH_DONE;
        end
      end
      PH_DIGIT: begin
        if (is_digit) begin
          cb_mag = dg_mag;
          cb_failed = dg_failed;
        end else begin
          if (char_byte != CH_NUL) begin
            cb_failed = 1'b1;
          end
          cb_phase = PH_DONE;
        end
      end
      default: begin
        cb_phase = src_phase;
      end
    endcase
  end

  always_comb begin
    phase_next = phase;
    counted_next = counted;
    magnitude_next = magnitude;
    negative_next = negative;
    failed_next = failed;
    if (!no_chars) begin
      if (phase == PH_BLANK) begin
        if (!is_blank) begin
          counted_next = CNT_W'(1);
          if (char_byte == CH_NUL) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = cb_phase;
            magnitude_next = cb_mag;
            negative_next = cb_negative;
            failed_next = cb_failed;
          end
        end
      end else if (phase != PH_DONE && counted < CNT_LIMIT) begin
        counted_next = counted + 1'b1;
        phase_next = cb_phase;
        magnitude_next = cb_mag;
        negative_next = cb_negative;
        failed_next = cb_failed;
      end
    end
    res.ok = ((phase_next == PH_DIGIT) || (phase_next == PH_DONE)) && !failed_next;
    res.value = '0;
    if (res.ok) begin
      res.value = negative_next ? $signed(~magnitude_next + 1'b1) : $signed(magnitude_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_BLANK;
      counted <= '0;
      magnitude <= '0;
      negative <= 1'b0;
      failed <= 1'b0;
    end else if (step) begin
      if (last) begin
        phase <= PH_BLANK;
        counted <= '0;
        magnitude <= '0;
        negative <= 1'b0;
        failed <= 1'b0;
      end else begin
        phase <= phase_next;
        counted <= counted_next;
        magnitude <= magnitude_next;
        negative <= negative_next;
        failed <= failed_next;
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/decimal_string_to_int32.sv
// a request is registered in the input stage, parsed when that stage advances, and for a final
// byte the parse result is registered in the output stage, where it is held until taken
// throughput: one byte per cycle, but a final byte waits while an unread result is held
// reset: rst is synchronous, active high; it empties both registers and restarts the parse
`default_nettype none
module decimal_string_to_int32 #(
  parameter int BUFFER_BYTES = dsi_pkg::BUFFER_BYTES_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  dsi_in_if.sink    chars,
  dsi_out_if.source result
);
  import dsi_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_none;
  logic       s1_adv;
  result_t    res;
  logic       out_valid;
  result_t    out_res;

  assign s1_adv = s1_valid && (!s1_last || !out_valid || result.ready);
  assign chars.ready = !s1_valid || s1_adv;

  dsi_parse #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_adv),
    .char_byte (s1_byte),
    .last      (s1_last),
    .no_chars  (s1_none),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_byte <= chars.char_byte;
      s1_last <= chars.last;
      s1_none <= chars.no_chars;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      out_res <= res;
    end
  end

  assign result.valid = out_valid;
  assign result.value = out_res.value;
  assign result.ok = out_res.ok;

`include "decimal_string_to_int32_assert.svh"

  `DSI_ASSERT_NEXT(a_stall_holds, s1_valid && s1_last && out_valid && !result.ready, s1_valid)
  `DSI_ASSERT_NEXT(a_final_gives_result, s1_adv && s1_last, result.valid)
  `DSI_ASSERT_NOW(a_fail_is_zero, result.valid && !result.ok, result.value == '0)

endmodule
`default_nettype wire

FILE: dv/tb_decimal_string_to_int32.sv
`default_nettype none
module tb_decimal_string_to_int32;
  timeunit 1ns;
  timeprecision 1ps;

  import dsi_pkg::*;

  localparam int BUFFER_BYTES = BUFFER_BYTES_DEF;
  localparam int DECIMAL_BASE = 10;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 400;
  localparam int TARGET_BYTES = 1700;

  // table text: '@' goes out as a nul byte, '~' as a request with no byte
  localparam logic [7:0] NUL_MARK = "@";
  localparam logic [7:0] NO_BYTE_MARK = "~";
  localparam logic [8:0] NO_BYTE_ITEM = 9'h100;

  localparam result_t PARSE_FAIL = '{value: '0, ok: 1'b0};

  typedef enum int {NO_SIGN, PLUS_SIGN, MINUS_SIGN} sign_mark_t;

  typedef struct {
    string   text;
    bit      end_empty;
    bit      typed;
    result_t want;
  } directed_row_t;

  directed_row_t directed_rows [22] = '{
    '{"", 1'b1, 1'b1, PARSE_FAIL},
    '{" \t  ", 1'b0, 1'b1, PARSE_FAIL},
    '{"2147483647", 1'b0, 1'b1, '{value: 32'sh7FFFFFFF, ok: 1'b1}},
    '{"-2147483648", 1'b0, 1'b1, '{value: 32'sh80000000, ok: 1'b1}},
    '{"2147483648", 1'b0, 1'b1, PARSE_FAIL},
    '{"-2147483649", 1'b0, 1'b1, PARSE_FAIL},
    '{"+", 1'b0, 1'b1, PARSE_FAIL},
    '{"-", 1'b0, 1'b1, PARSE_FAIL},
    '{"\011\012\013\014\015 ", 1'b0, 1'b1, PARSE_FAIL},
    '{"12ab", 1'b0, 1'b1, PARSE_FAIL},
    '{"@123", 1'b0, 1'b1, '{value: 32'sd0, ok: 1'b1}},
    '{"42@x9", 1'b0, 1'b1, '{value: 32'sd42, ok: 1'b1}},
    '{"  -0", 1'b0, 1'b0, PARSE_FAIL},
    '{"+0099", 1'b0, 1'b0, PARSE_FAIL},
    '{"- 5", 1'b0, 1'b1, PARSE_FAIL},
    '{"\377", 1'b0, 1'b1, PARSE_FAIL},
    '{"7~3", 1'b0, 1'b0, PARSE_FAIL},
    '{"-15", 1'b1, 1'b0, PARSE_FAIL},
    '{"  000000000000000000000000000123456x", 1'b0, 1'b0, PARSE_FAIL},
    '{"\t \012+17", 1'b0, 1'b0, PARSE_FAIL},
    '{"99999999999", 1'b0, 1'b1, PARSE_FAIL},
    '{"~", 1'b1, 1'b0, PARSE_FAIL}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  dsi_in_if  chars_if ();
  dsi_out_if result_if ();

  decimal_string_to_int32 DUT (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .result (result_if)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // parser state mirror
  phase_t      parse_phase;
  int          counted_bytes;
  logic [31:0] magnitude;
  bit          negative;
  bit          parse_failed;

  result_t pending_parses[$];
  int      bytes_sent;
  int      results_taken;
  int      errors;
  bit      steady_flow;

  function automatic void clear_parse();
    parse_phase = PH_BLANK;
    counted_bytes = 0;
    magnitude = '0;
    negative = 1'b0;
    parse_failed = 1'b0;
  endfunction

  function automatic void accumulate_digit(input logic [7:0] c);
    logic [ACC_W-1:0] grown;
    if (parse_failed) return;
    grown = {{(ACC_W-MAG_W){1'b0}}, magnitude} * DECIMAL_BASE + (c - CH_ZERO);
    if (grown > (negative ? LIMIT_NEG : LIMIT_POS)) parse_failed = 1'b1;
    else magnitude = grown[MAG_W-1:0];
  endfunction

  function automatic bit parse_item(input logic [7:0] c, input bit fin, input bit none,
                                    output result_t res);
    bit counted;
    bit digit;
    res = PARSE_FAIL;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (!none) begin
      counted = 1'b1;
      if (parse_phase == PH_BLANK) begin
        if (c == CH_SPACE || c == CH_TAB) begin
          counted = 1'b0;
        end else begin
          counted_bytes = 1;
          if (c == CH_NUL) begin
            parse_phase = PH_DONE;
            counted = 1'b0;
          end else begin
            parse_phase = PH_SPACE;
          end
        end
      end else if (parse_phase == PH_DONE || counted_bytes >= BUFFER_BYTES - 1) begin
        counted = 1'b0;
      end else begin
        counted_bytes++;
      end
      if (counted) begin
        case (parse_phase)
          PH_SPACE: begin
            if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
              if (c == CH_PLUS || c == CH_MINUS) begin
                negative = (c == CH_MINUS);
                parse_phase = PH_SIGN;
              end else if (digit) begin
                accumulate_digit(c);
                parse_phase = PH_DIGIT;
              end else begin
                parse_failed = 1'b1;
                parse_phase = PH_DONE;
              end
            end
          end
          PH_SIGN: begin
            if (digit) begin
              accumulate_digit(c);
              parse_phase = PH_DIGIT;
            end else begin
              parse_failed = 1'b1;
              parse_phase = PH_DONE;
            end
          end
          PH_DIGIT: begin
            if (digit) begin
              accumulate_digit(c);
            end else begin
              if (c != CH_NUL) parse_failed = 1'b1;
              parse_phase = PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end
    if (!fin) return 1'b0;
    res.ok = (parse_phase == PH_DIGIT || parse_phase == PH_DONE) && !parse_failed;
    if (res.ok) res.value = negative ? (32'd0 - magnitude) : magnitude;
    clear_parse();
    return 1'b1;
  endfunction

  function automatic void make_number_text(ref logic [8:0] q[$], input int unsigned mag,
                                           input sign_mark_t sign, input int zeros);
    string digits;
    int i;
    repeat ($urandom_range(0, 3)) q.push_back({1'b0, $urandom_range(0, 1) ? CH_SPACE : CH_TAB});
    if ($urandom_range(0, 3) == 0)
      q.push_back({1'b0, $urandom_range(0, 5) == 0 ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4))});
    case (sign)
      PLUS_SIGN:  q.push_back({1'b0, CH_PLUS});
      MINUS_SIGN: q.push_back({1'b0, CH_MINUS});
      default: ;
    endcase
    repeat (zeros) q.push_back({1'b0, CH_ZERO});
    digits = $sformatf("%0d", mag);
    for (i = 0; i < digits.len(); i++) q.push_back({1'b0, digits[i]});
  endfunction

  task automatic send_item(input logic [7:0] c, input bit fin, input bit none, input bit typed,
                           input result_t typed_res);
    int gap;
    result_t got;
    gap = steady_flow ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.char_byte <= none ? 8'($urandom) : c;
    chars_if.last <= fin;
    chars_if.no_chars <= none;
    do @(posedge clk); while (!chars_if.ready);
    if (parse_item(c, fin, none, got)) pending_parses.push_back(typed ? typed_res : got);
    if (!(none && !fin)) bytes_sent++;
  endtask

  task automatic send_string(input logic [8:0] q[$], input bit end_empty, input bit typed,
                             input result_t want, input bit sprinkle);
    int i;
    bit fin_here;
    for (i = 0; i < q.size(); i++) begin
      if (sprinkle && $urandom_range(0, 23) == 0) send_item(8'h00, 1'b0, 1'b1, typed, want);
      fin_here = (i == q.size() - 1) && !end_empty;
      send_item(q[i][7:0], fin_here, q[i][8], typed, want);
    end
    if (end_empty || q.size() == 0) send_item(8'h00, 1'b1, 1'b1, typed, want);
  endtask

  initial begin : stimulus
    logic [8:0]  text_q[$];
    logic [7:0]  ch;
    int          r;
    int          i;
    int          kind;
    int          strings_done;
    int unsigned mag;
    chars_if.valid = 1'b0;
    chars_if.char_byte = '0;
    chars_if.last = 1'b0;
    chars_if.no_chars = 1'b0;
    steady_flow = 1'b0;
    bytes_sent = 0;
    errors = 0;
    strings_done = 0;
    clear_parse();
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    for (r = 0; r < $size(directed_rows); r++) begin
      text_q.delete();
      for (i = 0; i < directed_rows[r].text.len(); i++) begin
        ch = directed_rows[r].text[i];
        if (ch == NUL_MARK) text_q.push_back({1'b0, CH_NUL});
        else if (ch == NO_BYTE_MARK) text_q.push_back(NO_BYTE_ITEM);
        else text_q.push_back({1'b0, ch});
      end
      send_string(text_q, directed_rows[r].end_empty, directed_rows[r].typed,
                  directed_rows[r].want, 1'b0);
    end

    while (bytes_sent < TARGET_BYTES) begin
      if (strings_done % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      text_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // plain numbers, then ones around the int32 limits
        if (kind < 55) mag = $urandom >> $urandom_range(0, 31);
        else mag = 32'd2147483645 + $urandom_range(0, 6);
        make_number_text(text_q, mag, sign_mark_t'($urandom_range(0, 2)),
                         $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
        if ($urandom_range(0, 9) == 0) begin
          text_q.push_back({1'b0, CH_NUL});
          repeat ($urandom_range(0, 3)) text_q.push_back({1'b0, 8'($urandom)});
        end else if ($urandom_range(0, 9) == 0) begin
          text_q.push_back({1'b0, 8'($urandom)});
        end
      end else if (kind < 75) begin
        // long runs of leading zeros, which may pass the end of the counted text
        make_number_text(text_q, $urandom >> $urandom_range(0, 31),
                         sign_mark_t'($urandom_range(0, 2)), $urandom_range(25, 40));
      end else if (kind < 88) begin
        make_number_text(text_q, $urandom >> $urandom_range(0, 31),
                         sign_mark_t'($urandom_range(0, 2)), $urandom_range(0, 3));
        text_q[$urandom_range(0, text_q.size() - 1)] = {1'b0, 8'($urandom)};
      end else begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 1)) text_q.push_back({1'b0, 8'($urandom)});
          else text_q.push_back({1'b0, 8'(CH_TAB + $urandom_range(0, CH_NINE - CH_TAB))});
        end
      end
      send_string(text_q, $urandom_range(0, 11) == 0, 1'b0, PARSE_FAIL, 1'b1);
      strings_done++;
    end

    @(negedge clk);
    chars_if.valid <= 1'b0;
    while (pending_parses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin : result_sink
    int      stall;
    bit      long_hold_done;
    result_t want;
    result_if.ready = 1'b0;
    results_taken = 0;
    long_hold_done = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      stall = steady_flow ? 0 : $urandom_range(0, 16);
      // one long hold so the parser backs up and stalls its request side
      if (!long_hold_done && results_taken == 50) begin
        stall = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
      results_taken++;
      if (pending_parses.size() == 0) begin
        $error("unexpected result: value %0d ok %0b", result_if.value, result_if.ok);
        errors++;
      end else begin
        want = pending_parses.pop_front();
        if (result_if.value !== want.value) begin
          $error("value: expected %0d, actual %0d", want.value, result_if.value);
          errors++;
        end
        if (result_if.ok !== want.ok) begin
          $error("ok: expected %0b, actual %0b", want.ok, result_if.ok);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    wait (!rst);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((chars_if.valid && chars_if.ready) || (result_if.valid && result_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
+incdir+design
design/dsi_pkg.sv
design/dsi_in_if.sv
design/dsi_out_if.sv
design/dsi_digit.sv
design/dsi_parse.sv
design/decimal_string_to_int32.sv
dv/tb_decimal_string_to_int32.sv
